// ===== rtl/gola_pkg.sv =====
package gola_pkg;

    localparam int MAX_GRAIN_DEF  = 1024;
    localparam int RING_DEPTH_DEF = 2048;
    localparam int MIN_GRAIN      = 4;

    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int RECIP_W    = 32;
    localparam int DIV_STEPS  = 33;
    localparam int DIV_CNT_W  = 6;
    localparam int PHASE_W    = 10;
    localparam int COS_W      = 18;
    localparam int WIN_W      = 16;
    localparam int PROD_W     = 33;
    localparam int WSAMP_W    = 17;

    localparam logic [LEN_W-1:0] GRAIN_LENGTH_RST = 11'd1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_REVERSE = 2'd0,
        MODE_MUTE    = 2'd1,
        MODE_SWAP    = 2'd2,
        MODE_BYPASS  = 2'd3
    } grain_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAIN_MODE   = 1'd0,
        REG_GRAIN_LENGTH = 1'd1
    } cfg_reg_t;

    // quarter-wave sine coefficients, q30
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598668;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026988;
    localparam logic [63:0] SC9 = 64'd172272;

    typedef logic [16:0] sin_tab_t [0:256];

    // sin(pi/2 * q/256) in q16, evaluated at elaboration
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int q = 0; q <= 256; q++) begin
            x  = 64'(q) << 22;
            x2 = (x * x) >> 30;
            t  = SC9;
            t  = SC7 - ((x2 * t) >> 30);
            t  = SC5 - ((x2 * t) >> 30);
            t  = SC3 - ((x2 * t) >> 30);
            t  = SC1 - ((x2 * t) >> 30);
            s  = (x * t) >> 30;
            s  = (s + 64'd8192) >> 14;
            if (s > 64'd65536) begin
                s = 64'd65536;
            end
            tab[q] = s[16:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== rtl/gola_ram.sv =====
module gola_ram #(
    parameter int DEPTH = gola_pkg::RING_DEPTH_DEF,
    parameter int WIDTH = gola_pkg::SAMPLE_W
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gola_recip.sv =====
module gola_recip #(
    parameter int GW = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [GW-1:0]                divisor,
    output logic                         busy,
    output logic [gola_pkg::RECIP_W-1:0] quotient
);

    logic                          busy_reg;
    logic [gola_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [GW-1:0]                 rem_reg;
    logic [gola_pkg::RECIP_W-1:0]  quo_reg;
    logic [GW:0]                   trial;
    logic                          fits;

    // dividend is 2^32: only its first bit is set
    always_comb begin
        trial = {rem_reg, (cnt_reg == gola_pkg::DIV_CNT_W'(gola_pkg::DIV_STEPS))};
        fits  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= gola_pkg::DIV_CNT_W'(gola_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == gola_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? GW'(trial - {1'b0, divisor}) : trial[GW-1:0];
            quo_reg <= {quo_reg[gola_pkg::RECIP_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/gola_window.sv =====
module gola_window #(
    parameter int GW = 11
) (
    input  logic                                aclk,
    input  logic [GW-1:0]                       j_idx,
    input  logic [gola_pkg::RECIP_W-1:0]        recip,
    input  logic signed [gola_pkg::SAMPLE_W-1:0] x,
    output logic signed [gola_pkg::WSAMP_W-1:0]  v
);

    localparam int RECIP_W_PAD = gola_pkg::RECIP_W;
    localparam int PROD_W_CAST = gola_pkg::PROD_W;

    logic [GW+gola_pkg::RECIP_W-1:0]     phase_prod;
    logic [gola_pkg::RECIP_W-1:0]        phase_sum;
    logic [gola_pkg::PHASE_W-1:0]        k_reg;
    logic [1:0]                          quad;
    logic [8:0]                          q;
    logic [16:0]                         sin_val;
    logic signed [gola_pkg::COS_W-1:0]   cos_reg;
    logic signed [gola_pkg::COS_W:0]     diff;
    logic [16:0]                         w17;
    logic [gola_pkg::WIN_W-1:0]          w;
    logic signed [gola_pkg::PROD_W-1:0]  prod_reg;
    logic signed [gola_pkg::PROD_W-1:0]  rounded;

    // stage 1: table phase from j * recip
    always_comb begin
        phase_prod = {{RECIP_W_PAD{1'b0}}, j_idx} * {{GW{1'b0}}, recip};
        phase_sum  = phase_prod[gola_pkg::RECIP_W-1:0] + 32'h0020_0000;
    end

    // stage 2: cosine from the quarter-wave table
    always_comb begin
        quad    = k_reg[9:8];
        q       = quad[0] ? {1'b0, k_reg[7:0]} : 9'd256 - {1'b0, k_reg[7:0]};
        sin_val = gola_pkg::SIN_TAB[q];
    end

    // stage 3: hann weight and sample product
    always_comb begin
        diff = 19'sd65536 - {cos_reg[gola_pkg::COS_W-1], cos_reg};
        w17  = diff[17:1];
        w    = w17[16] ? 16'hffff : w17[15:0];
    end

    always_ff @(posedge aclk) begin
        k_reg    <= phase_sum[31:22];
        cos_reg  <= (quad[1] ^ quad[0]) ? -$signed({1'b0, sin_val}) : $signed({1'b0, sin_val});
        prod_reg <= PROD_W_CAST'(x) * PROD_W_CAST'($signed({1'b0, w}));
    end

    // round half up, q0.16 back to q1.15
    assign rounded = prod_reg + 33'sd32768;
    assign v       = rounded[gola_pkg::PROD_W-1:16];

endmodule

// ===== rtl/granular_overlap_add_engine.sv =====
// Hann-windowed overlap-add granulator. One signed Q1.15 sample in gives one
// sample out. Every input beat reads and clears the output ring at the current
// position, stores the input there and advances. Every half grain the last
// grain of input is windowed and, per grain_mode, reversed, muted on alternate
// grains, half-swapped or passed, then added with saturation into the output
// ring half a maximum grain ahead. After reset a clearing pass over every ring
// address zeroes both rings, with s_ready low. A sample goes through accept,
// ring clear and result load, which waits for a free result register. When a
// hop completes, the grain first waits for the 33-step reciprocal of G-1, while
// its offsets are reduced one ring length per cycle alongside, then walks each
// grain sample through read, cosine lookup, multiply and write-back on the
// single-port rings. A result waiting on m_ready does not stop grain work; the
// next beat is taken once the result register is free.
module granular_overlap_add_engine #(
    parameter int MAX_GRAIN  = gola_pkg::MAX_GRAIN_DEF,
    parameter int RING_DEPTH = gola_pkg::RING_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gola_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gola_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gola_pkg::SAMPLE_W-1:0]  s_in_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [gola_pkg::SAMPLE_W-1:0]  m_out_sample
);

    localparam int AW       = $clog2(RING_DEPTH);
    localparam int GW       = $clog2(MAX_GRAIN + 1);
    localparam int HW       = $clog2(MAX_GRAIN / 2 + 1);
    localparam int HALF_MOD = (MAX_GRAIN / 2) % RING_DEPTH;
    localparam int G_MAX    = MAX_GRAIN - (MAX_GRAIN % 2);
    localparam int SW       = gola_pkg::SAMPLE_W;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_HAND  = 8'b0000_1000,
        S_SETUP = 8'b0001_0000,
        S_G0    = 8'b0010_0000,
        S_G1    = 8'b0100_0000,
        S_G2    = 8'b1000_0000
    } state_t;

    // note: a fourth grain phase reuses the encoding space via a flag
    state_t state_reg, state_next;
    logic   g3_reg;

    // configuration
    logic [gola_pkg::MODE_W-1:0] mode_reg;
    logic [gola_pkg::LEN_W-1:0]  len_reg;

    // ring bookkeeping
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [HW-1:0] hop_reg;
    logic [HW-1:0] hop_inc;
    logic          fire_reg;
    logic          mute_reg;
    logic          muted_reg;

    // grain walk
    logic [GW-1:0] gm_reg;
    logic [GW-1:0] hm_reg;
    logic [GW-1:0] j_reg;
    logic [GW-1:0] n_reg;
    logic [AW-1:0] in_addr_reg;
    logic [AW-1:0] out_addr_reg;
    logic [AW-1:0] start_reg;
    logic          mod_done;

    // result register
    logic                 m_valid_reg;
    logic signed [SW-1:0] m_sample_reg;

    // grain size
    logic [31:0]   g_wide;
    logic [GW-1:0] g;
    logic [GW-1:0] g_half;

    // ring ports
    logic                 in_en, in_we;
    logic [AW-1:0]        in_addr;
    logic [SW-1:0]        in_wdata, in_rdata;
    logic                 out_en, out_we;
    logic [AW-1:0]        out_addr;
    logic [SW-1:0]        out_wdata, out_rdata;

    // arithmetic
    logic                               recip_start;
    logic                               recip_busy;
    logic [gola_pkg::RECIP_W-1:0]       recip;
    logic signed [gola_pkg::WSAMP_W-1:0] v;
    logic signed [SW+1:0]               acc;
    logic [SW-1:0]                      acc_sat;
    logic [AW:0]                        wpos;
    logic                               out_free;
    logic                               beat_in;

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            d = d + (AW+1)'(RING_DEPTH);
        end
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(RING_DEPTH - 1) : a - 1'b1;
    endfunction

    // grain length: even, clamped to [MIN_GRAIN, MAX_GRAIN]
    always_comb begin
        g_wide = 32'({len_reg[gola_pkg::LEN_W-1:1], 1'b0});
        if (g_wide < 32'(gola_pkg::MIN_GRAIN)) begin
            g_wide = 32'(gola_pkg::MIN_GRAIN);
        end
        if (g_wide > 32'(MAX_GRAIN)) begin
            g_wide = 32'(G_MAX);
        end
        g      = g_wide[GW-1:0];
        g_half = g >> 1;
    end

    assign hop_inc  = hop_reg + 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && !g3_reg && out_free;
    assign beat_in  = s_valid && s_ready;
    assign mod_done = (32'(gm_reg) < 32'(RING_DEPTH)) && (32'(hm_reg) < 32'(RING_DEPTH));
    assign wpos     = {1'b0, pos_reg} + (AW+1)'(HALF_MOD);
    assign recip_start = (state_reg == S_HAND) && out_free && fire_reg;

    // saturating accumulate into the output ring
    always_comb begin
        acc = $signed({{2{out_rdata[SW-1]}}, out_rdata})
            + (muted_reg ? '0 : $signed({v[gola_pkg::WSAMP_W-1], v}));
        if (acc > 18'sd32767) begin
            acc_sat = 16'h7fff;
        end else if (acc < -18'sd32768) begin
            acc_sat = 16'h8000;
        end else begin
            acc_sat = acc[SW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == AW'(RING_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (g3_reg) begin
                    state_next = (n_reg == g - 1'b1) ? S_IDLE : S_G0;
                end else if (beat_in) begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_HAND;
            S_HAND: begin
                if (out_free) begin
                    state_next = fire_reg ? S_SETUP : S_IDLE;
                end
            end
            S_SETUP: begin
                if (!recip_busy && mod_done) begin
                    state_next = S_G0;
                end
            end
            S_G0:    state_next = S_G1;
            S_G1:    state_next = S_G2;
            S_G2:    state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // ring port muxing
    always_comb begin
        in_en     = 1'b0;
        in_we     = 1'b0;
        in_addr   = pos_reg;
        in_wdata  = s_in_sample;
        out_en    = 1'b0;
        out_we    = 1'b0;
        out_addr  = pos_reg;
        out_wdata = '0;
        unique case (state_reg)
            S_CLEAR: begin
                in_en    = 1'b1;
                in_we    = 1'b1;
                in_addr  = clr_addr_reg;
                in_wdata = '0;
                out_en   = 1'b1;
                out_we   = 1'b1;
                out_addr = clr_addr_reg;
            end
            S_IDLE: begin
                if (g3_reg) begin
                    out_en    = 1'b1;
                    out_we    = 1'b1;
                    out_addr  = out_addr_reg;
                    out_wdata = acc_sat;
                end else if (beat_in) begin
                    in_en  = 1'b1;
                    in_we  = 1'b1;
                    out_en = 1'b1;
                end
            end
            S_READ: begin
                out_en = 1'b1;
                out_we = 1'b1;
            end
            S_G0: begin
                in_en    = 1'b1;
                in_addr  = in_addr_reg;
                out_en   = 1'b1;
                out_addr = out_addr_reg;
            end
            S_HAND, S_SETUP, S_G1, S_G2: begin
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= gola_pkg::MODE_BYPASS;
            len_reg  <= gola_pkg::GRAIN_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gola_pkg::REG_GRAIN_MODE:   mode_reg <= cfg_wdata[gola_pkg::MODE_W-1:0];
                gola_pkg::REG_GRAIN_LENGTH: len_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            g3_reg       <= 1'b0;
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            hop_reg      <= '0;
            fire_reg     <= 1'b0;
            mute_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            // the write-back phase sits in idle with a flag so s_ready stays low
            g3_reg    <= (state_reg == S_G2);
            // load a new result, or drop the one just taken
            if (state_reg == S_HAND && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: clr_addr_reg <= clr_addr_reg + 1'b1;
                S_READ: begin
                    pos_reg  <= wrap_inc(pos_reg);
                    fire_reg <= (32'(hop_inc) >= 32'(g_half));
                    hop_reg  <= (32'(hop_inc) >= 32'(g_half)) ? '0 : hop_inc;
                end
                S_IDLE: begin
                    if (g3_reg && (n_reg == g - 1'b1)
                        && (mode_reg == gola_pkg::MODE_MUTE)) begin
                        mute_reg <= !mute_reg;
                    end
                end
                S_HAND, S_SETUP, S_G0, S_G1, S_G2: begin
                end
                default: begin
                end
            endcase
        end
    end

    // result payload and grain walk registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_HAND && out_free) begin
            m_sample_reg <= $signed(out_rdata);
        end
        if (recip_start) begin
            gm_reg    <= g;
            hm_reg    <= g_half;
            muted_reg <= (mode_reg == gola_pkg::MODE_MUTE) && mute_reg;
        end else if (state_reg == S_SETUP) begin
            if (32'(gm_reg) >= 32'(RING_DEPTH)) begin
                gm_reg <= gm_reg - GW'(RING_DEPTH);
            end
            if (32'(hm_reg) >= 32'(RING_DEPTH)) begin
                hm_reg <= hm_reg - GW'(RING_DEPTH);
            end
            if (mod_done) begin
                start_reg    <= wrap_sub(pos_reg, AW'(gm_reg));
                n_reg        <= '0;
                out_addr_reg <= (wpos >= (AW+1)'(RING_DEPTH))
                                ? AW'(wpos - (AW+1)'(RING_DEPTH)) : wpos[AW-1:0];
                case (mode_reg)
                    gola_pkg::MODE_REVERSE: begin
                        j_reg       <= g - 1'b1;
                        in_addr_reg <= wrap_dec(pos_reg);
                    end
                    gola_pkg::MODE_SWAP: begin
                        j_reg       <= g_half;
                        in_addr_reg <= wrap_sub(pos_reg, AW'(hm_reg));
                    end
                    default: begin
                        j_reg       <= '0;
                        in_addr_reg <= wrap_sub(pos_reg, AW'(gm_reg));
                    end
                endcase
            end
        end else if (state_reg == S_IDLE && g3_reg) begin
            n_reg        <= n_reg + 1'b1;
            out_addr_reg <= wrap_inc(out_addr_reg);
            case (mode_reg)
                gola_pkg::MODE_REVERSE: begin
                    j_reg       <= j_reg - 1'b1;
                    in_addr_reg <= wrap_dec(in_addr_reg);
                end
                gola_pkg::MODE_SWAP: begin
                    if (j_reg == g - 1'b1) begin
                        j_reg       <= '0;
                        in_addr_reg <= start_reg;
                    end else begin
                        j_reg       <= j_reg + 1'b1;
                        in_addr_reg <= wrap_inc(in_addr_reg);
                    end
                end
                default: begin
                    j_reg       <= j_reg + 1'b1;
                    in_addr_reg <= wrap_inc(in_addr_reg);
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;

    gola_ram #(.DEPTH(RING_DEPTH), .WIDTH(SW)) u_in_ring (
        .aclk  (aclk),
        .en    (in_en),
        .we    (in_we),
        .addr  (in_addr),
        .wdata (in_wdata),
        .rdata (in_rdata)
    );

    gola_ram #(.DEPTH(RING_DEPTH), .WIDTH(SW)) u_out_ring (
        .aclk  (aclk),
        .en    (out_en),
        .we    (out_we),
        .addr  (out_addr),
        .wdata (out_wdata),
        .rdata (out_rdata)
    );

    gola_recip #(.GW(GW)) u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (recip_start),
        .divisor  (g - 1'b1),
        .busy     (recip_busy),
        .quotient (recip)
    );

    gola_window #(.GW(GW)) u_window (
        .aclk  (aclk),
        .j_idx (j_reg),
        .recip (recip),
        .x     ($signed(in_rdata)),
        .v     (v)
    );

    // an accepted beat always moves to the ring clear cycle
    a_beat_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_in |=> state_reg == S_READ)
        else $error("accepted beat did not enter read");

    // grain walk never starts with the reciprocal still running
    a_recip_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_G0 |-> !recip_busy)
        else $error("grain walk started before reciprocal done");

    // a result appears only out of the load cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_HAND))
        else $error("result valid from wrong state");

    // no beat is taken during the write-back phase
    a_no_beat_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        g3_reg |-> !s_ready)
        else $error("beat accepted during grain write-back");

endmodule

// ===== bench/granular_overlap_add_engine_tb.sv =====
`timescale 1ns / 1ps

module granular_overlap_add_engine_tb;

    localparam int MAX_G      = 1024;
    localparam int RING       = 2048;
    // grain work after the last result: reciprocal plus the walk over each grain sample
    localparam int DRAIN_WAIT = 6000;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [gola_pkg::CFG_IDX_W-1:0]       cfg_index = gola_pkg::REG_GRAIN_MODE;
    logic [gola_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [gola_pkg::SAMPLE_W-1:0] s_in_sample = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [gola_pkg::SAMPLE_W-1:0] m_out_sample;

    always #1 aclk = ~aclk;

    granular_overlap_add_engine u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample  (s_in_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample)
    );

    // ---------------------------------------------------------------
    // granulator model state
    // ---------------------------------------------------------------
    int                    in_ring  [RING];
    int                    out_ring [RING];
    int                    wr_pos;
    int                    hop_cnt;
    bit                    mute_on;
    gola_pkg::grain_mode_t cur_mode;
    logic [10:0]           cur_len;

    // expected output samples, oldest first, plus directed known values
    logic signed [15:0] out_sample_q [$];
    bit                 known_q      [$];
    logic signed [15:0] known_val_q  [$];

    bit                 drv_known;
    logic signed [15:0] drv_known_val;

    int errors   = 0;
    int send_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    // quarter-wave sine in q16, 9th order odd polynomial in q30
    function automatic longint quarter_wave(int q);
        logic [63:0] x, x2, t, s;
        x  = 64'(q & 511) << 22;
        x2 = (x * x) >> 30;
        t  = 64'd172272;
        t  = 64'd5026988 - ((x2 * t) >> 30);
        t  = 64'd85569306 - ((x2 * t) >> 30);
        t  = 64'd693598668 - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) s = 64'd65536;
        return longint'(s);
    endfunction

    function automatic longint cos_phase(int k);
        int r;
        r = k & 255;
        case ((k >> 8) & 3)
            0: return quarter_wave(256 - r);
            1: return -quarter_wave(r);
            2: return -quarter_wave(256 - r);
            default: return quarter_wave(r);
        endcase
    endfunction

    function automatic int hann_sample(int start, int j, longint recip);
        longint k, w, p;
        k = ((longint'(j) * recip + (64'd1 << 21)) >> 22) & 1023;
        w = (65536 - cos_phase(int'(k))) >>> 1;
        if (w > 65535) w = 65535;
        p = longint'(in_ring[(start + j) % RING]) * w + 32768;
        return int'(p >>> 16);
    endfunction

    function automatic int eff_grain();
        int g;
        g = cur_len & 11'h7FE;
        if (g < gola_pkg::MIN_GRAIN) g = gola_pkg::MIN_GRAIN;
        if (g > MAX_G) g = MAX_G;
        return g;
    endfunction

    function automatic void add_grain(int g);
        int     start, wpos, j, v, sum, idx;
        longint recip;
        bit     muted;
        start = (wr_pos + RING - g) % RING;
        wpos  = (wr_pos + MAX_G / 2) % RING;
        recip = (64'd1 << 32) / (g - 1);
        muted = (cur_mode == gola_pkg::MODE_MUTE) && mute_on;
        for (int n = 0; n < g; n++) begin
            idx = (wpos + n) % RING;
            case (cur_mode)
                gola_pkg::MODE_REVERSE: j = g - 1 - n;
                gola_pkg::MODE_SWAP:    j = (n + g / 2) % g;
                default:                j = n;
            endcase
            v   = muted ? 0 : hann_sample(start, j, recip);
            sum = out_ring[idx] + v;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            out_ring[idx] = sum;
        end
        if (cur_mode == gola_pkg::MODE_MUTE) mute_on = !mute_on;
    endfunction

    // one sample in: returns the sample that leaves the output ring
    function automatic int granulate(int x);
        int y, g;
        y = out_ring[wr_pos];
        out_ring[wr_pos] = 0;
        in_ring[wr_pos]  = x;
        wr_pos = (wr_pos + 1) % RING;
        g = eff_grain();
        hop_cnt++;
        if (hop_cnt >= g / 2) begin
            add_grain(g);
            hop_cnt = 0;
        end
        return y;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off when asked
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // beat monitor: check results first, then predict accepted samples
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (out_sample_q.size() == 0) begin
                    $display("%0t: unexpected result out_sample=%0d", $realtime, m_out_sample);
                    errors++;
                end else begin
                    want = out_sample_q.pop_front();
                    if (m_out_sample !== want) begin
                        $display("%0t: out_sample mismatch expected %0d actual %0d",
                                 $realtime, want, m_out_sample);
                        errors++;
                    end
                    if (known_q.pop_front()) begin
                        want = known_val_q.pop_front();
                        if (m_out_sample !== want) begin
                            $display("%0t: directed out_sample expected %0d actual %0d",
                                     $realtime, want, m_out_sample);
                            errors++;
                        end
                    end else begin
                        void'(known_val_q.pop_front());
                    end
                end
            end
            if (s_valid && s_ready) begin
                out_sample_q.push_back(16'(granulate(int'(s_in_sample))));
                known_q.push_back(drv_known);
                known_val_q.push_back(drv_known_val);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------
    task automatic send_beat(logic signed [15:0] x, bit known, logic signed [15:0] kval);
        if ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_pct);
        end
        s_valid       <= 1'b1;
        s_in_sample   <= x;
        drv_known     <= known;
        drv_known_val <= kval;
        do @(posedge aclk); while (!s_ready);
    endtask

    // registers change only with the block idle and the grain work drained
    task automatic write_reg(gola_pkg::cfg_reg_t idx, logic [10:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (out_sample_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == gola_pkg::REG_GRAIN_MODE) cur_mode = gola_pkg::grain_mode_t'(val[1:0]);
        else cur_len = val;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(3))
            0: case ($urandom_range(4))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'shFFFF;
                default: return 16'sh0001;
            endcase
            default: return 16'($urandom);
        endcase
    endfunction

    typedef struct {
        logic signed [15:0] x;
        bit                 known;
        logic signed [15:0] kval;
    } dir_row_t;

    // after reset the output ring is all zeros until the first grain lands
    dir_row_t dir_rows [] = '{
        '{16'sh7FFF, 1, 0}, '{16'sh8000, 1, 0}, '{16'sh0000, 1, 0},
        '{16'sh0001, 1, 0}, '{16'shFFFF, 1, 0}, '{16'sh4000, 1, 0},
        '{16'shC000, 1, 0}, '{16'sh5555, 1, 0}, '{16'shAAAA, 1, 0},
        '{16'sh7FFE, 1, 0}, '{16'sh8001, 1, 0}, '{16'sh0100, 1, 0},
        '{16'sh7FFF, 0, 0}, '{16'sh7FFF, 0, 0}, '{16'sh8000, 0, 0},
        '{16'sh8000, 0, 0}, '{16'sh1234, 0, 0}, '{16'shEDCB, 0, 0},
        '{16'sh0F0F, 0, 0}, '{16'shF0F0, 0, 0}
    };

    typedef struct {
        gola_pkg::grain_mode_t mode;
        int                    len;   // negative: pick a random length
        int                    beats;
        int                    idle;  // 0 none, 1 sender, 2 receiver, 3 both
        bit                    squeeze;
    } phase_t;

    // odd lengths, out-of-range lengths (below min, above max) and
    // shrinking the grain mid-hop are all in here
    phase_t phases [] = '{
        '{gola_pkg::MODE_BYPASS,  1024, 300, 0, 0},
        '{gola_pkg::MODE_REVERSE,  256, 150, 1, 0},
        '{gola_pkg::MODE_MUTE,     257, 150, 2, 0},
        '{gola_pkg::MODE_SWAP,    1023, 200, 3, 0},
        '{gola_pkg::MODE_MUTE,       3,  60, 0, 0},
        '{gola_pkg::MODE_REVERSE, 2047, 200, 2, 1},
        '{gola_pkg::MODE_SWAP,       0,  60, 1, 0},
        '{gola_pkg::MODE_MUTE,     512, 150, 3, 0},
        '{gola_pkg::MODE_REVERSE,   -1, 150, 0, 0},
        '{gola_pkg::MODE_SWAP,     256, 150, 2, 0},
        '{gola_pkg::MODE_BYPASS,   300, 100, 1, 0}
    };

    initial begin
        for (int i = 0; i < RING; i++) begin
            in_ring[i]  = 0;
            out_ring[i] = 0;
        end
        wr_pos   = 0;
        hop_cnt  = 0;
        mute_on  = 0;
        cur_mode = gola_pkg::MODE_BYPASS;
        cur_len  = gola_pkg::GRAIN_LENGTH_RST;
        drv_known = 0;
        drv_known_val = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed beats at reset settings, no idling
        foreach (dir_rows[i]) send_beat(dir_rows[i].x, dir_rows[i].known, dir_rows[i].kval);

        foreach (phases[p]) begin
            write_reg(gola_pkg::REG_GRAIN_MODE, 11'(phases[p].mode));
            write_reg(gola_pkg::REG_GRAIN_LENGTH,
                      phases[p].len < 0 ? 11'($urandom_range(256, 1024))
                                        : 11'(phases[p].len));
            send_pct  = (phases[p].idle == 1) ? 76 : (phases[p].idle == 3) ? 20 : 0;
            stall_pct = (phases[p].idle == 2) ? 76 : (phases[p].idle == 3) ? 20 : 0;
            // long receiver hold-off so the block backs up into its input
            if (phases[p].squeeze) hold_cycles = 3000;
            for (int n = 0; n < phases[p].beats; n++) send_beat(rand_sample(), 0, 0);
        end

        s_valid <= 1'b0;
        while (out_sample_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
